/* src/slrp_pkg.sv */
`default_nettype none

package slrp_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int POS_W   = ADDR_W + 1;
  localparam int HALF    = 1 << (SAMPLE_BITS - 2);
  localparam int WORD_W  = SAMPLE_BITS - 1;
  localparam int STORE_W = 2 * WORD_W;

  localparam int LEN_W  = 17;
  localparam int GAIN_W = 10;
  localparam int MIX_W  = 9;
  localparam int OCT_W  = 2;

  localparam int LOOP_LENGTH_RST = 19661;
  localparam int GAIN_RST        = 179;
  localparam int DRY_WET_RST     = 128;
  localparam int GAIN_MAX        = 512;
  localparam int MIX_MAX         = 256;
  localparam int MIX_MID         = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DRY_WET       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SHIFT  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PRESENT = CFG_IDX_W'(4);

  localparam int FRAC_BITS = 8;
  localparam int MIX_SHIFT = 16;
  localparam int RND_BYTE  = 1 << (FRAC_BITS - 1);
  localparam int RND_WORD  = 1 << (MIX_SHIFT - 1);

  localparam int DRY_W   = SAMPLE_BITS + 2;
  localparam int MAC_A_W = DRY_W + FRAC_BITS;
  localparam int MAC_B_W = GAIN_W + 1;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WORD_W-1:0]      word_t;
  typedef logic signed [DRY_W-1:0]       dry_t;
  typedef logic signed [MAC_A_W-1:0]     mac_a_t;
  typedef logic signed [MAC_B_W-1:0]     mac_b_t;
  typedef logic signed [MAC_P_W-1:0]     mac_p_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_BYTE,
    SH_WORD
  } shift_e;

  typedef struct packed {
    logic   start;
    mac_a_t a;
    mac_b_t b;
    mac_p_t addend;
    shift_e shift;
    logic   clamp;
  } mac_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  len;
    logic [GAIN_W-1:0] gain;
    logic [MIX_W-1:0]  mix;
    logic [MIX_W-1:0]  comp;
    logic [OCT_W-1:0]  octave;
    logic              right_present;
  } cfg_t;

endpackage

`default_nettype wire

/* src/slrp_if.sv */
`default_nettype none

interface slrp_cfg_if;
  import slrp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface slrp_in_if;
  import slrp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  logic    record_gate;
  logic    erase_gate;
  logic    octave_gate;
  modport source (output valid, left_in, right_in, record_gate, erase_gate, octave_gate,
                  input ready);
  modport sink (input valid, left_in, right_in, record_gate, erase_gate, octave_gate,
                output ready);
endinterface

interface slrp_out_if;
  import slrp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

/* src/slrp_cfg.sv */
`default_nettype none

module slrp_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  slrp_cfg_if.sink        cfg_i,
  output slrp_pkg::cfg_t  cfg_o
);
  import slrp_pkg::*;

  logic [LEN_W-1:0]  loop_length_q;
  logic [GAIN_W-1:0] gain_q;
  logic [MIX_W-1:0]  dry_wet_q;
  logic [OCT_W-1:0]  octave_q;
  logic              right_present_q;
  logic [MIX_W-1:0]  mix;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q   <= LEN_W'(LOOP_LENGTH_RST);
      gain_q          <= GAIN_W'(GAIN_RST);
      dry_wet_q       <= MIX_W'(DRY_WET_RST);
      octave_q        <= '0;
      right_present_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LOOP_LENGTH:   loop_length_q   <= cfg_i.data[LEN_W-1:0];
        REG_GAIN:          gain_q          <= cfg_i.data[GAIN_W-1:0];
        REG_DRY_WET:       dry_wet_q       <= cfg_i.data[MIX_W-1:0];
        REG_OCTAVE_SHIFT:  octave_q        <= cfg_i.data[OCT_W-1:0];
        REG_RIGHT_PRESENT: right_present_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign mix = (dry_wet_q > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : dry_wet_q;

  always_comb begin
    cfg_o = '0;
    if (loop_length_q == '0) begin
      cfg_o.len = POS_W'(1);
    end else if (32'(loop_length_q) > 32'(STORE_DEPTH)) begin
      cfg_o.len = POS_W'(STORE_DEPTH);
    end else begin
      cfg_o.len = POS_W'(loop_length_q);
    end
    cfg_o.gain = (gain_q > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : gain_q;
    cfg_o.mix  = mix;
    if (mix <= MIX_W'(MIX_MID)) begin
      cfg_o.comp = MIX_W'((MIX_W+1)'(MIX_MAX) + (MIX_W+1)'(mix));
    end else begin
      cfg_o.comp = MIX_W'((MIX_W+1)'(2 * MIX_MAX) - (MIX_W+1)'(mix));
    end
    cfg_o.octave        = octave_q;
    cfg_o.right_present = right_present_q;
  end

endmodule

`default_nettype wire

/* src/slrp_mac.sv */
`default_nettype none

module slrp_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slrp_pkg::mac_req_t req_i,
  output logic               done_o,
  output slrp_pkg::mac_a_t   res_o
);
  import slrp_pkg::*;

  localparam int SUM_W = MAC_P_W + 1;

  mac_p_t prod_d;
  mac_p_t prod_q;
  mac_p_t addend_q;
  shift_e shift_q;
  logic   clamp_q;
  logic   v1_q;
  logic   v2_q;
  mac_a_t res_q;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W-1:0] limited;

  assign prod_d = req_i.a * req_i.b;

  always_comb begin
    sum = SUM_W'(prod_q) + SUM_W'(addend_q);
    unique case (shift_q)
      SH_BYTE: shifted = sum >>> FRAC_BITS;
      SH_WORD: shifted = sum >>> MIX_SHIFT;
      default: shifted = sum;
    endcase
    limited = shifted;
    if (clamp_q) begin
      if (shifted > SUM_W'(HALF)) begin
        limited = SUM_W'(HALF);
      end else if (shifted < -SUM_W'(HALF)) begin
        limited = -SUM_W'(HALF);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q   <= prod_d;
      addend_q <= req_i.addend;
      shift_q  <= req_i.shift;
      clamp_q  <= req_i.clamp;
    end
    if (v1_q) begin
      res_q <= mac_a_t'(limited);
    end
  end

  assign done_o = v2_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* src/slrp_store.sv */
`default_nettype none

module slrp_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [slrp_pkg::ADDR_W-1:0]  addr_i,
  input  logic [slrp_pkg::STORE_W-1:0] wdata_i,
  output logic [slrp_pkg::STORE_W-1:0] rdata_o
);
  import slrp_pkg::*;

  logic [STORE_W-1:0] mem [STORE_DEPTH];
  logic [STORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/stereo_loop_recorder_player.sv */
// Channel    Dir  Payload                                        Handshake
// cfg_i      in   index, data                                    valid/ready, ready held high
// frame_i    in   left_in, right_in, record/erase/octave gates   valid/ready
// result_o   out  left_out, right_out                            valid/ready, output register
//
// A request holds the sequencer from acceptance through eight passes through the
// shared multiply/round/clamp unit, plus store write, store read, position step and
// result load; a new request is accepted only once the sequencer is back in idle. The
// position step repeats for each extra wrap of the read position.
// After reset a sweep over all STORE_DEPTH (65536) addresses zeroes the store before the first
// request; an erase edge runs the same sweep inside its request.
// A waiting result does not block the next request; a finished request waits only while
// the previous result is still unread.
`default_nettype none

module stereo_loop_recorder_player (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrp_cfg_if.sink    cfg_i,
  slrp_in_if.sink     frame_i,
  slrp_out_if.source  result_o
);
  import slrp_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRY_L,
    ST_DRY_R,
    ST_WRITE,
    ST_READ,
    ST_WET_L,
    ST_WET_R,
    ST_MIX_L1,
    ST_MIX_L2,
    ST_MIX_R1,
    ST_MIX_R2,
    ST_STEP,
    ST_DONE
  } state_e;

  cfg_t     cfg;
  mac_req_t mac_req;
  logic     mac_done;
  mac_a_t   mac_res;
  logic     arith;

  logic               store_we;
  logic               store_re;
  logic [ADDR_W-1:0]  store_addr;
  logic [STORE_W-1:0] store_wdata;
  logic [STORE_W-1:0] store_rdata;

  state_e            state_q;
  logic              busy_q;
  logic              resume_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [POS_W-1:0]  wp_q;
  logic [ADDR_W-1:0] rp_q;
  logic              last_rec_q;
  logic              last_era_q;
  logic              out_valid_q;

  sample_t          left_q;
  sample_t          right_q;
  logic             oct_gate_q;
  dry_t             dry_l_q;
  dry_t             dry_r_q;
  sample_t          wet_l_q;
  sample_t          wet_r_q;
  mac_a_t           mix_q;
  sample_t          out_l_q;
  sample_t          out_r_q;
  sample_t          res_l_q;
  sample_t          res_r_q;
  logic [POS_W-1:0] sum_q;

  logic frame_accept;
  logic result_load;

  slrp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  slrp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  slrp_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .re_i    (store_re),
    .addr_i  (store_addr),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata)
  );

  assign frame_i.ready   = (state_q == ST_IDLE);
  assign frame_accept    = frame_i.valid && (state_q == ST_IDLE);
  assign result_load     = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);
  assign result_o.valid     = out_valid_q;
  assign result_o.left_out  = res_l_q;
  assign result_o.right_out = res_r_q;

  always_comb begin
    mac_req        = '0;
    arith          = 1'b1;
    mac_req.b      = mac_b_t'(cfg.gain);
    mac_req.addend = mac_p_t'(RND_BYTE);
    mac_req.shift  = SH_BYTE;
    mac_req.clamp  = 1'b0;
    unique case (state_q)
      ST_DRY_L: mac_req.a = mac_a_t'(left_q);
      ST_DRY_R: mac_req.a = mac_a_t'(right_q);
      ST_WET_L: begin
        mac_req.a     = mac_a_t'(word_t'(store_rdata[WORD_W-1:0]));
        mac_req.clamp = 1'b1;
      end
      ST_WET_R: begin
        mac_req.a     = mac_a_t'(word_t'(store_rdata[STORE_W-1:WORD_W]));
        mac_req.clamp = 1'b1;
      end
      ST_MIX_L1: begin
        mac_req.a      = mac_a_t'(wet_l_q) - mac_a_t'(dry_l_q);
        mac_req.b      = mac_b_t'(cfg.mix);
        mac_req.addend = mac_p_t'(dry_l_q) <<< FRAC_BITS;
        mac_req.shift  = SH_NONE;
      end
      ST_MIX_R1: begin
        mac_req.a      = mac_a_t'(wet_r_q) - mac_a_t'(dry_r_q);
        mac_req.b      = mac_b_t'(cfg.mix);
        mac_req.addend = mac_p_t'(dry_r_q) <<< FRAC_BITS;
        mac_req.shift  = SH_NONE;
      end
      ST_MIX_L2, ST_MIX_R2: begin
        mac_req.a      = mix_q;
        mac_req.b      = mac_b_t'(cfg.comp);
        mac_req.addend = mac_p_t'(RND_WORD);
        mac_req.shift  = SH_WORD;
        mac_req.clamp  = 1'b1;
      end
      default: arith = 1'b0;
    endcase
    mac_req.start = arith && !busy_q;
  end

  always_comb begin
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_addr  = rp_q;
    store_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        store_we   = 1'b1;
        store_addr = clr_cnt_q;
      end
      ST_WRITE: begin
        store_we    = (wp_q < POS_W'(STORE_DEPTH));
        store_addr  = wp_q[ADDR_W-1:0];
        store_wdata = {dry_r_q[WORD_W-1:0], dry_l_q[WORD_W-1:0]};
      end
      ST_READ: store_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      busy_q      <= 1'b0;
      resume_q    <= 1'b0;
      clr_cnt_q   <= '0;
      wp_q        <= POS_W'(STORE_DEPTH);
      rp_q        <= '0;
      last_rec_q  <= 1'b0;
      last_era_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (mac_done) begin
        busy_q <= 1'b0;
      end else if (mac_req.start) begin
        busy_q <= 1'b1;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
            resume_q <= 1'b0;
            state_q  <= resume_q ? ST_DRY_L : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (frame_i.valid) begin
            last_rec_q <= frame_i.record_gate;
            last_era_q <= frame_i.erase_gate;
            if (frame_i.record_gate && !last_rec_q) begin
              wp_q <= '0;
            end
            if (frame_i.erase_gate && !last_era_q) begin
              resume_q <= 1'b1;
              state_q  <= ST_CLEAR;
            end else begin
              state_q <= ST_DRY_L;
            end
          end
        end
        ST_DRY_L:  if (mac_done) state_q <= ST_DRY_R;
        ST_DRY_R:  if (mac_done) state_q <= ST_WRITE;
        ST_WRITE: begin
          if (wp_q < POS_W'(STORE_DEPTH)) begin
            wp_q <= wp_q + 1'b1;
          end
          state_q <= ST_READ;
        end
        ST_READ:   state_q <= ST_WET_L;
        ST_WET_L:  if (mac_done) state_q <= ST_WET_R;
        ST_WET_R:  if (mac_done) state_q <= ST_MIX_L1;
        ST_MIX_L1: if (mac_done) state_q <= ST_MIX_L2;
        ST_MIX_L2: if (mac_done) state_q <= ST_MIX_R1;
        ST_MIX_R1: if (mac_done) state_q <= ST_MIX_R2;
        ST_MIX_R2: if (mac_done) state_q <= ST_STEP;
        ST_STEP: begin
          if (sum_q < cfg.len) begin
            rp_q    <= sum_q[ADDR_W-1:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (result_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_accept) begin
      left_q     <= frame_i.left_in;
      right_q    <= cfg.right_present ? frame_i.right_in : frame_i.left_in;
      oct_gate_q <= frame_i.octave_gate;
    end
    if (state_q == ST_READ) begin
      sum_q <= POS_W'(rp_q) + POS_W'(cfg.octave) + POS_W'(oct_gate_q) + POS_W'(1);
    end
    if ((state_q == ST_STEP) && (sum_q >= cfg.len)) begin
      sum_q <= sum_q - cfg.len;
    end
    if (mac_done) begin
      unique case (state_q)
        ST_DRY_L:  dry_l_q <= dry_t'(mac_res);
        ST_DRY_R:  dry_r_q <= dry_t'(mac_res);
        ST_WET_L:  wet_l_q <= sample_t'(mac_res);
        ST_WET_R:  wet_r_q <= sample_t'(mac_res);
        ST_MIX_L1, ST_MIX_R1: mix_q <= mac_res;
        ST_MIX_L2: out_l_q <= sample_t'(mac_res);
        ST_MIX_R2: out_r_q <= sample_t'(mac_res);
        default: ;
      endcase
    end
    if (result_load) begin
      res_l_q <= out_l_q;
      res_r_q <= out_r_q;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid && frame_i.ready |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_write_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= POS_W'(STORE_DEPTH))
    else $error("write position beyond store depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the done step");

  a_mac_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_req.start |-> ##2 mac_done)
    else $error("shared unit did not finish in two cycles");

endmodule

`default_nettype wire
